/* sv/t2tag_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package t2tag_pkg;

    // Default geometry
    localparam int PAGE_COUNT_DEF     = 135;
    localparam int MAX_FAST_PAGES_DEF = 14;

    // Word counter width, wide enough for the default fast read cap (14)
    localparam int CNT_W = 7;

    // Queue depths
    localparam int CMDQ_DEPTH  = 4;
    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

    // Opcodes
    localparam logic [7:0] OPC_READ    = 8'h30;
    localparam logic [7:0] OPC_VERSION = 8'h60;
    localparam logic [7:0] OPC_AUTH    = 8'h1B;
    localparam logic [7:0] OPC_FAST    = 8'h3A;

    // Minimum frame lengths per opcode
    localparam logic [5:0] LEN_READ    = 6'd2;
    localparam logic [5:0] LEN_VERSION = 6'd2;
    localparam logic [5:0] LEN_AUTH    = 6'd5;
    localparam logic [5:0] LEN_FAST    = 6'd3;

    // Fixed response words, first byte in bits 7:0
    localparam logic [31:0] VERSION_WORD0 = 32'h0204_0400;
    localparam logic [31:0] VERSION_WORD1 = 32'h0311_0001;
    localparam logic [31:0] PACK_WORD     = 32'h0000_8080;
    localparam logic [31:0] ACK_WORD      = 32'h0000_000A;
    localparam logic [31:0] NACK_WORD     = 32'h0000_0000;

    localparam logic [2:0] BYTES_FULL = 3'd4;
    localparam logic [2:0] BYTES_PACK = 3'd2;
    localparam logic [2:0] BYTES_ONE  = 3'd1;

    // Work kinds carried through the command queue
    typedef enum logic [2:0] {
        K_LOAD,
        K_READ,
        K_VERSION,
        K_AUTH,
        K_FAST,
        K_NACK,
        K_ACK
    } kind_t;

    // Back end sequencer states
    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } state_t;

    // Classified item
    typedef struct packed {
        kind_t             kind;
        logic [7:0]        page;
        logic [31:0]       word;
        logic [7:0]        start;
        logic [CNT_W-1:0]  count;
    } cmd_t;

    // Result beat
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
        logic        served;
    } beat_t;

endpackage

`default_nettype wire

/* sv/type2_tag_command_responder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Path: a command's first result beat passes the command queue, the sequencer
//   registers, the word stage and the result queue; a load is written once taken.
// Flow: a command of N words (N up to 14 for a fast read by default) issues one
//   word and at most one page memory read per cycle while the result queue has room.
// Reset: rst_n clears queues, sequencer and the served flag; page memory is
//   not cleared and holds undefined data until loaded.

module type2_tag_command_responder_top #(
    parameter int PAGE_COUNT     = t2tag_pkg::PAGE_COUNT_DEF,
    parameter int MAX_FAST_PAGES = t2tag_pkg::MAX_FAST_PAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        mode,
    input  wire logic [7:0]  load_page,
    input  wire logic [31:0] load_word,
    input  wire logic [7:0]  cmd_code,
    input  wire logic [7:0]  arg_first,
    input  wire logic [7:0]  arg_second,
    input  wire logic [5:0]  cmd_length,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      resp_word,
    output logic [2:0]       resp_bytes,
    output logic             last,
    output logic             served
);
    import t2tag_pkg::*;

    localparam int CMD_W  = $bits(cmd_t);
    localparam int BEAT_W = $bits(beat_t);

    logic                           cq_push;
    cmd_t                           cq_wdata;
    logic [CMD_W-1:0]               cq_rdata;
    logic                           cq_pop;
    logic                           cq_empty;
    logic [$clog2(CMDQ_DEPTH+1)-1:0] cq_count;

    logic                           oq_push;
    beat_t                          oq_wdata;
    logic [BEAT_W-1:0]              oq_rdata;
    logic                           oq_full;
    logic [OUTQ_CNT_W-1:0]          oq_count;
    beat_t                          head;

    // Front end: classify accepted beats
    t2tag_front #(
        .PAGE_COUNT     (PAGE_COUNT),
        .MAX_FAST_PAGES (MAX_FAST_PAGES)
    ) u_front (
        .push       (push),
        .q_full     (full),
        .mode       (mode),
        .load_page  (load_page),
        .load_word  (load_word),
        .cmd_code   (cmd_code),
        .arg_first  (arg_first),
        .arg_second (arg_second),
        .cmd_length (cmd_length),
        .q_push     (cq_push),
        .q_data     (cq_wdata)
    );

    // Command queue between front and back
    t2tag_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cq_push),
        .wr_data (cq_wdata),
        .rd_en   (cq_pop),
        .rd_data (cq_rdata),
        .full    (full),
        .empty   (cq_empty),
        .count   (cq_count)
    );

    // Back end: memory and response sequencing
    t2tag_back #(
        .PAGE_COUNT (PAGE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (cq_empty),
        .q_data    (cmd_t'(cq_rdata)),
        .q_pop     (cq_pop),
        .out_count (oq_count),
        .out_push  (oq_push),
        .out_data  (oq_wdata)
    );

    // Result queue
    t2tag_fifo #(
        .WIDTH (BEAT_W),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (oq_push),
        .wr_data (oq_wdata),
        .rd_en   (pop),
        .rd_data (oq_rdata),
        .full    (oq_full),
        .empty   (empty),
        .count   (oq_count)
    );

    assign head       = beat_t'(oq_rdata);
    assign resp_word  = head.word;
    assign resp_bytes = head.nbytes;
    assign last       = head.last;
    assign served     = head.served;

    // Queue bookkeeping stays consistent
    a_cmdq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cq_count <= ($clog2(CMDQ_DEPTH+1))'(CMDQ_DEPTH))
        else $error("command queue over capacity");

    a_outq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        oq_full |-> !oq_push)
        else $error("result queue overflow");

    a_empty_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && mode && cmd_length == '0) |=> ($past(cq_count) == cq_count
            || $past(cq_pop))
        )
        else $error("empty frame entered the command queue");

endmodule

`default_nettype wire

/* sv/t2tag_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module t2tag_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    output logic      [WIDTH-1:0]           rd_data,
    output logic                            full,
    output logic                            empty,
    output logic      [$clog2(DEPTH+1)-1:0] count
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = store_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* sv/t2tag_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module t2tag_front #(
    parameter int PAGE_COUNT     = 135,
    parameter int MAX_FAST_PAGES = 14
) (
    input  wire logic              push,
    input  wire logic              q_full,
    input  wire logic              mode,
    input  wire logic [7:0]        load_page,
    input  wire logic [31:0]       load_word,
    input  wire logic [7:0]        cmd_code,
    input  wire logic [7:0]        arg_first,
    input  wire logic [7:0]        arg_second,
    input  wire logic [5:0]        cmd_length,
    output logic                   q_push,
    output t2tag_pkg::cmd_t        q_data
);
    import t2tag_pkg::*;

    logic [8:0] fast_span;
    logic       fast_ok;
    logic       drop;

    // Fast read range check and word count
    assign fast_span = {1'b0, arg_second} - {1'b0, arg_first} + 9'd1;
    assign fast_ok   = (arg_first <= arg_second) && ({1'b0, arg_second} < 9'(PAGE_COUNT));

    // Empty frames are swallowed here
    assign drop   = mode && (cmd_length == '0);
    assign q_push = push && !q_full && !drop;

    // Classify the beat
    always_comb
    begin
        q_data       = '0;
        q_data.page  = load_page;
        q_data.word  = load_word;
        q_data.start = arg_first;
        if (!mode)
        begin
            q_data.kind  = K_LOAD;
            q_data.count = '0;
        end
        else if (cmd_code == OPC_READ && cmd_length >= LEN_READ)
        begin
            q_data.kind  = K_READ;
            q_data.count = CNT_W'(4);
        end
        else if (cmd_code == OPC_VERSION && cmd_length >= LEN_VERSION)
        begin
            q_data.kind  = K_VERSION;
            q_data.count = CNT_W'(2);
        end
        else if (cmd_code == OPC_AUTH && cmd_length >= LEN_AUTH)
        begin
            q_data.kind  = K_AUTH;
            q_data.count = CNT_W'(1);
        end
        else if (cmd_code == OPC_FAST && cmd_length >= LEN_FAST)
        begin
            if (fast_ok)
            begin
                q_data.kind  = K_FAST;
                q_data.count = (fast_span > 9'(MAX_FAST_PAGES)) ? CNT_W'(MAX_FAST_PAGES)
                                                                 : CNT_W'(fast_span);
            end
            else
            begin
                q_data.kind  = K_NACK;
                q_data.count = CNT_W'(1);
            end
        end
        else
        begin
            q_data.kind  = K_ACK;
            q_data.count = CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

/* sv/t2tag_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module t2tag_back #(
    parameter int PAGE_COUNT = 135
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    input  wire t2tag_pkg::cmd_t              q_data,
    output logic                              q_pop,
    input  wire logic [t2tag_pkg::OUTQ_CNT_W-1:0] out_count,
    output logic                              out_push,
    output t2tag_pkg::beat_t                  out_data
);
    import t2tag_pkg::*;

    localparam int IDX_W = $clog2(PAGE_COUNT);

    // Page memory, contents undefined until loaded
    logic [31:0]      mem [PAGE_COUNT];
    logic [31:0]      rd_data_reg;
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       start_reg, start_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             served_reg, served_next;

    // Word stage between issue and result queue
    logic             s1_valid_reg;
    logic             s1_mem_reg, s1_mem_next;
    logic             s1_zero_reg, s1_zero_next;
    logic [31:0]      s1_word_reg, s1_word_next;
    logic [2:0]       s1_bytes_reg, s1_bytes_next;
    logic             s1_last_reg, s1_last_next;
    logic             s1_served_reg;

    logic             take;
    logic             issue;
    logic             room;
    logic             word_last;
    logic [7:0]       cur_page;
    logic             page_hit;
    logic             sets_served;

    assign take        = (state_reg == S_IDLE) && !q_empty;
    assign room        = s1_valid_reg ? (out_count < OUTQ_CNT_W'(OUTQ_DEPTH - 1))
                                      : (out_count < OUTQ_CNT_W'(OUTQ_DEPTH));
    assign issue       = (state_reg == S_RUN) && room;
    assign word_last   = (idx_reg == cnt_reg - 1'b1);
    assign cur_page    = start_reg + {1'b0, idx_reg};
    assign page_hit    = {1'b0, cur_page} < 9'(PAGE_COUNT);
    assign sets_served = (q_data.kind == K_READ) || (q_data.kind == K_AUTH)
                      || (q_data.kind == K_FAST);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take && q_data.kind != K_LOAD)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (issue && word_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs and word generation
    always_comb
    begin
        q_pop         = take;
        mem_we        = take && (q_data.kind == K_LOAD)
                      && ({1'b0, q_data.page} < 9'(PAGE_COUNT));
        mem_waddr     = q_data.page[IDX_W-1:0];
        mem_re        = issue && page_hit;
        mem_raddr     = cur_page[IDX_W-1:0];
        kind_next     = kind_reg;
        start_next    = start_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        served_next   = served_reg;
        s1_mem_next   = 1'b0;
        s1_zero_next  = !page_hit;
        s1_word_next  = NACK_WORD;
        s1_bytes_next = BYTES_FULL;
        s1_last_next  = word_last;

        if (take && q_data.kind != K_LOAD)
        begin
            kind_next   = q_data.kind;
            start_next  = q_data.start;
            cnt_next    = q_data.count;
            idx_next    = '0;
            served_next = served_reg | sets_served;
        end
        if (issue)
        begin
            idx_next = idx_reg + 1'b1;
        end

        case (kind_reg)
            K_READ, K_FAST:
            begin
                s1_mem_next = 1'b1;
            end
            K_VERSION:
            begin
                s1_word_next = (idx_reg == '0) ? VERSION_WORD0 : VERSION_WORD1;
            end
            K_AUTH:
            begin
                s1_word_next  = PACK_WORD;
                s1_bytes_next = BYTES_PACK;
            end
            K_NACK:
            begin
                s1_word_next  = NACK_WORD;
                s1_bytes_next = BYTES_ONE;
            end
            K_ACK:
            begin
                s1_word_next  = ACK_WORD;
                s1_bytes_next = BYTES_ONE;
            end
            default:
            begin
                s1_word_next = NACK_WORD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            kind_reg     <= K_ACK;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            served_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            served_reg   <= served_next;
            s1_valid_reg <= issue;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        if (issue)
        begin
            s1_mem_reg    <= s1_mem_next;
            s1_zero_reg   <= s1_zero_next;
            s1_word_reg   <= s1_word_next;
            s1_bytes_reg  <= s1_bytes_next;
            s1_last_reg   <= s1_last_next;
            s1_served_reg <= served_reg;
        end
    end

    // Page memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= q_data.word;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Result beat into the output queue
    always_comb
    begin
        out_push        = s1_valid_reg;
        out_data.word   = s1_mem_reg ? (s1_zero_reg ? '0 : rd_data_reg) : s1_word_reg;
        out_data.nbytes = s1_bytes_reg;
        out_data.last   = s1_last_reg;
        out_data.served = s1_served_reg;
    end

    // A pushed beat always finds room in the output queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (out_count < OUTQ_CNT_W'(OUTQ_DEPTH)))
        else $error("result beat pushed into a full output queue");

    // The word index stays inside the response while running
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (idx_reg < cnt_reg))
        else $error("word index past response length");

    // Served flag is sticky
    a_served_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        served_reg |=> served_reg)
        else $error("served flag cleared");

    // The queue is only drained while idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE) && !q_empty)
        else $error("command popped while busy");

endmodule

`default_nettype wire

/* bench/type2_tag_command_responder_top_tb.sv */
`timescale 1ns / 1ps

module type2_tag_command_responder_top_tb;

    import t2tag_pkg::*;

    localparam int PAGES        = PAGE_COUNT_DEF;
    localparam int MAX_FAST     = MAX_FAST_PAGES_DEF;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 1000;

    // Minimum frame lengths per opcode
    localparam logic [5:0] READ_MIN_LEN    = 6'd2;
    localparam logic [5:0] VERSION_MIN_LEN = 6'd2;
    localparam logic [5:0] AUTH_MIN_LEN    = 6'd5;
    localparam logic [5:0] FAST_MIN_LEN    = 6'd3;

    // Fixed answers, first byte in bits 7:0
    localparam logic [31:0] VERSION_LOW  = 32'h0204_0400;   // 00 04 04 02
    localparam logic [31:0] VERSION_HIGH = 32'h0311_0001;   // 01 00 11 03
    localparam logic [31:0] PACK_REPLY   = 32'h0000_8080;
    localparam logic [31:0] ACK_REPLY    = 32'h0000_000A;
    localparam logic [31:0] NACK_REPLY   = 32'h0000_0000;

    typedef struct {
        logic        mode;
        logic [7:0]  load_page;
        logic [31:0] load_word;
        logic [7:0]  cmd_code;
        logic [7:0]  arg_first;
        logic [7:0]  arg_second;
        logic [5:0]  cmd_length;
    } frame_t;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
        logic        served;
    } resp_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        mode;
    logic [7:0]  load_page;
    logic [31:0] load_word;
    logic [7:0]  cmd_code;
    logic [7:0]  arg_first;
    logic [7:0]  arg_second;
    logic [5:0]  cmd_length;
    logic        empty;
    logic        pop;
    logic [31:0] resp_word;
    logic [2:0]  resp_bytes;
    logic        last;
    logic        served;

    // Tag image and sticky flag as the block should hold them
    logic [31:0] page_store [0:PAGES-1];
    bit          page_loaded [0:PAGES-1];
    logic        served_state;
    resp_beat_t  resp_q[$];

    int unsigned send_idle_pct;
    int unsigned pop_stall_pct;
    int          frames_taken;
    int          beats_checked;
    int          mismatches;
    int          quiet_cycles;

    type2_tag_command_responder_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .load_page  (load_page),
        .load_word  (load_word),
        .cmd_code   (cmd_code),
        .arg_first  (arg_first),
        .arg_second (arg_second),
        .cmd_length (cmd_length),
        .empty      (empty),
        .pop        (pop),
        .resp_word  (resp_word),
        .resp_bytes (resp_bytes),
        .last       (last),
        .served     (served)
    );

    always #2 clk = ~clk;

    // Expected response beats
    function automatic void add_beat(logic [31:0] word, logic [2:0] nbytes, logic is_last);
        resp_beat_t b;
        b.word   = word;
        b.nbytes = nbytes;
        b.last   = is_last;
        b.served = served_state;
        resp_q.push_back(b);
    endfunction

    // Tag behavior for one accepted beat
    function automatic void predict_frame(frame_t f);
        logic [7:0] p;
        int         span;
        if (!f.mode) begin
            if (f.load_page < PAGES)
                page_store[f.load_page] = f.load_word;
            return;
        end
        if (f.cmd_length == 6'd0)
            return;
        if (f.cmd_code == OPC_READ && f.cmd_length >= READ_MIN_LEN) begin
            served_state = 1'b1;
            for (int i = 0; i < 4; i++) begin
                p = f.arg_first + 8'(i);
                add_beat((p < PAGES) ? page_store[p] : 32'h0, 3'd4, i == 3);
            end
        end else if (f.cmd_code == OPC_VERSION && f.cmd_length >= VERSION_MIN_LEN) begin
            add_beat(VERSION_LOW, 3'd4, 1'b0);
            add_beat(VERSION_HIGH, 3'd4, 1'b1);
        end else if (f.cmd_code == OPC_AUTH && f.cmd_length >= AUTH_MIN_LEN) begin
            served_state = 1'b1;
            add_beat(PACK_REPLY, 3'd2, 1'b1);
        end else if (f.cmd_code == OPC_FAST && f.cmd_length >= FAST_MIN_LEN) begin
            if (f.arg_first <= f.arg_second && f.arg_second < PAGES) begin
                served_state = 1'b1;
                span = int'(f.arg_second) - int'(f.arg_first) + 1;
                if (span > MAX_FAST)
                    span = MAX_FAST;
                for (int i = 0; i < span; i++)
                    add_beat(page_store[int'(f.arg_first) + i], 3'd4, i == span - 1);
            end else begin
                add_beat(NACK_REPLY, 3'd1, 1'b1);
            end
        end else begin
            add_beat(ACK_REPLY, 3'd1, 1'b1);
        end
    endfunction

    // One beat into the block; returns on the falling edge after acceptance
    task automatic send_item(input frame_t f);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        mode       <= f.mode;
        load_page  <= f.load_page;
        load_word  <= f.load_word;
        cmd_code   <= f.cmd_code;
        arg_first  <= f.arg_first;
        arg_second <= f.arg_second;
        cmd_length <= f.cmd_length;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_frame(f);
        frames_taken++;
        @(negedge clk);
    endtask

    // Page write; command fields carry noise
    task automatic send_load(input logic [7:0] page, input logic [31:0] word);
        frame_t f;
        f.mode       = 1'b0;
        f.load_page  = page;
        f.load_word  = word;
        f.cmd_code   = 8'($urandom);
        f.arg_first  = 8'($urandom);
        f.arg_second = 8'($urandom);
        f.cmd_length = 6'($urandom);
        if (page < PAGES)
            page_loaded[page] = 1'b1;
        send_item(f);
    endtask

    // Command frame; pages it will read get loaded first
    task automatic send_command(input logic [7:0] code, input logic [7:0] a1,
                                input logic [7:0] a2, input logic [5:0] len);
        frame_t     f;
        int         span;
        logic [7:0] p;
        span = 0;
        if (code == OPC_READ && len >= READ_MIN_LEN)
            span = 4;
        else if (code == OPC_FAST && len >= FAST_MIN_LEN && a1 <= a2 && a2 < PAGES)
            span = (int'(a2) - int'(a1) + 1 > MAX_FAST) ? MAX_FAST : int'(a2) - int'(a1) + 1;
        for (int i = 0; i < span; i++) begin
            p = a1 + 8'(i);
            if (p < PAGES && !page_loaded[p])
                send_load(p, $urandom);
        end
        f.mode       = 1'b1;
        f.load_page  = 8'($urandom);
        f.load_word  = $urandom;
        f.cmd_code   = code;
        f.arg_first  = a1;
        f.arg_second = a2;
        f.cmd_length = len;
        send_item(f);
    endtask

    // Let every expected beat come out, then a little more
    task automatic wait_drained();
        push <= 1'b0;
        while (resp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Fixed answers before anything sets the served flag
    task automatic test_version_and_ack();
        send_command(OPC_VERSION, 8'h00, 8'h00, VERSION_MIN_LEN);
        send_command(8'hFF, 8'hFF, 8'hFF, 6'd63);
        send_command(8'h00, 8'h00, 8'h00, 6'd1);
    endtask

    // Short frames of known opcodes get ACK; an empty frame gets nothing; a full AUTH follows
    task automatic test_short_and_empty_frames();
        send_command(OPC_READ, 8'h00, 8'h00, READ_MIN_LEN - 6'd1);
        send_command(OPC_VERSION, 8'h00, 8'h00, VERSION_MIN_LEN - 6'd1);
        send_command(OPC_AUTH, 8'h00, 8'h00, AUTH_MIN_LEN - 6'd1);
        send_command(OPC_FAST, 8'h00, 8'h05, FAST_MIN_LEN - 6'd1);
        send_command(OPC_READ, 8'h00, 8'h00, 6'd0);
        send_command(OPC_AUTH, 8'hA5, 8'h5A, AUTH_MIN_LEN);
    endtask

    // Page window at both ends of the memory and across the index wrap
    task automatic test_read_window_edges();
        send_load(8'd134, 32'hFFFF_FFFF);
        send_load(8'd0, 32'h0000_0000);
        send_load(8'd135, 32'hDEAD_BEEF);
        send_load(8'd255, 32'h1234_5678);
        send_command(OPC_READ, 8'd0, 8'h00, READ_MIN_LEN);
        send_command(OPC_READ, 8'd131, 8'h00, READ_MIN_LEN);
        send_command(OPC_READ, 8'd133, 8'h00, 6'd32);
        send_command(OPC_READ, 8'd253, 8'h00, 6'd33);
        send_command(OPC_READ, 8'd255, 8'hFF, 6'd63);
    endtask

    // Fast read: cap, single page, exact cap and each rejected range
    task automatic test_fast_read_ranges();
        send_command(OPC_FAST, 8'd0, 8'd134, FAST_MIN_LEN);
        send_command(OPC_FAST, 8'd134, 8'd134, 6'd63);
        send_command(OPC_FAST, 8'd121, 8'd134, 6'd4);
        send_command(OPC_FAST, 8'd0, 8'd0, 6'd3);
        send_command(OPC_FAST, 8'd5, 8'd4, 6'd3);
        send_command(OPC_FAST, 8'd10, 8'd135, 6'd3);
        send_command(OPC_FAST, 8'd255, 8'd255, 6'd40);
    endtask

    // Mostly valid commands over loaded pages, with noise and broken frames;
    // n counts every beat sent, page preloads included
    task automatic test_mixed_traffic(input int n);
        int          first_taken;
        int unsigned sel;
        logic [7:0]  code;
        logic [7:0]  a1;
        logic [7:0]  a2;
        first_taken = frames_taken;
        while (frames_taken - first_taken < n) begin
            sel = $urandom_range(99);
            a1  = 8'($urandom);
            a2  = 8'($urandom);
            if (sel < 25) begin
                if ($urandom_range(9) == 0)
                    send_load(8'($urandom_range(255, PAGES)), $urandom);
                else
                    send_load(8'($urandom_range(PAGES - 1)), $urandom);
            end else if (sel < 45) begin
                send_command(OPC_READ, a1, a2, 6'($urandom_range(63, READ_MIN_LEN)));
            end else if (sel < 53) begin
                send_command(OPC_VERSION, a1, a2, 6'($urandom_range(63, VERSION_MIN_LEN)));
            end else if (sel < 60) begin
                send_command(OPC_AUTH, a1, a2, 6'($urandom_range(63, AUTH_MIN_LEN)));
            end else if (sel < 78) begin
                a1 = 8'($urandom_range(PAGES - 1));
                if ($urandom_range(1) == 0)
                    a2 = 8'($urandom_range(PAGES - 1, a1));
                else
                    a2 = 8'((int'(a1) + $urandom_range(15) > PAGES - 1) ?
                            PAGES - 1 : int'(a1) + $urandom_range(15));
                send_command(OPC_FAST, a1, a2, 6'($urandom_range(63, FAST_MIN_LEN)));
            end else if (sel < 83) begin
                if ($urandom_range(1) == 0) begin
                    a1 = 8'($urandom_range(255, 1));
                    a2 = 8'($urandom_range(int'(a1) - 1));
                end else begin
                    a2 = 8'($urandom_range(255, PAGES));
                end
                send_command(OPC_FAST, a1, a2, 6'($urandom_range(63, FAST_MIN_LEN)));
            end else if (sel < 91) begin
                code = 8'($urandom);
                while (code == OPC_READ || code == OPC_VERSION ||
                       code == OPC_AUTH || code == OPC_FAST)
                    code = 8'($urandom);
                send_command(code, a1, a2, 6'($urandom_range(63, 1)));
            end else if (sel < 97) begin
                case ($urandom_range(3))
                    0: send_command(OPC_READ, a1, a2, 6'd1);
                    1: send_command(OPC_VERSION, a1, a2, 6'd1);
                    2: send_command(OPC_AUTH, a1, a2, 6'($urandom_range(AUTH_MIN_LEN - 1, 1)));
                    default: send_command(OPC_FAST, a1, a2,
                                          6'($urandom_range(FAST_MIN_LEN - 1, 1)));
                endcase
            end else begin
                send_command(8'($urandom), a1, a2, 6'd0);
            end
        end
    endtask

    // Receiver readiness, redrawn every cycle
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= pop_stall_pct);

    function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
        if (expv !== actv) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expv, actv);
            mismatches++;
        end
    endfunction

    // Compare each popped beat with the oldest expectation
    always @(posedge clk) begin
        resp_beat_t exp_beat;
        if (rst_n && pop && !empty) begin
            if (resp_q.size() == 0) begin
                $error("unexpected beat: resp_word 0x%0h", resp_word);
                mismatches++;
            end else begin
                exp_beat = resp_q.pop_front();
                check_field("resp_word", exp_beat.word, resp_word);
                check_field("resp_bytes", 32'(exp_beat.nbytes), 32'(resp_bytes));
                check_field("last", 32'(exp_beat.last), 32'(last));
                check_field("served", 32'(exp_beat.served), 32'(served));
                beats_checked++;
            end
        end
    end

    // Hang detection: cycles with no beat moving on either side
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        mode          = 1'b0;
        load_page     = 8'h00;
        load_word     = 32'h0;
        cmd_code      = 8'h00;
        arg_first     = 8'h00;
        arg_second    = 8'h00;
        cmd_length    = 6'd0;
        served_state  = 1'b0;
        frames_taken  = 0;
        beats_checked = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 13;
        pop_stall_pct = 67;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sender mostly busy, receiver mostly stalled
        test_version_and_ack();
        test_short_and_empty_frames();
        test_read_window_edges();
        test_fast_read_ranges();
        test_mixed_traffic(72);
        wait_drained();

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 67;
        pop_stall_pct = 13;
        test_mixed_traffic(72);
        wait_drained();

        // back to back on both sides
        send_idle_pct = 0;
        pop_stall_pct = 0;
        test_mixed_traffic(72);
        wait_drained();

        $display("Run covered %0d loads and frames, %0d response beats checked, %0d mismatches.",
                 frames_taken, beats_checked, mismatches);
        $display("Directed edges plus random traffic under three sender/receiver stall mixes.");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
